// File: rtl/hrsh_pkg.sv
package hrsh_pkg;

    localparam int PIECE_SIZE = 64;
    localparam int PIECES    = 4;
    localparam int ROUNDS    = 3;

    localparam int STAGES    = $clog2(PIECE_SIZE);
    localparam int ACC_W     = 40;
    localparam int SAMPLE_W  = 16;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 7;
    localparam int HC_W      = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;
    localparam int PIECE_W   = 2;
    localparam int ROUND_W   = 2;
    localparam int STAGE_W   = $clog2(STAGES + 1);
    localparam int USED_W    = $clog2(PIECES + 1);
    localparam int MASK_N    = ROUNDS * PIECES;
    localparam int MASK_AW   = $clog2(MASK_N);
    localparam int CNT_W     = $clog2(PIECE_SIZE);
    localparam int HC_MAX    = PIECE_SIZE * PIECES;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT    = 2'd1;

    localparam logic ACT_LOAD_MASK = 1'b0;
    localparam logic ACT_SAMPLE    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FLIP,
        ST_STAGE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               busy;
        logic               load;
        logic               flip;
        logic               stage_en;
        logic               emit;
        logic [STAGE_W-1:0] stage;
        logic [ROUND_W-1:0] round;
        logic [PIECE_W-1:0] piece;
    } t_cmd;

    typedef struct packed {
        logic              start;
        logic              out_free;
        logic [USED_W-1:0] used;
    } t_sts;

endpackage

// File: rtl/hrsh_ctrl.sv
module hrsh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hrsh_pkg::t_sts i_sts,
    output hrsh_pkg::t_cmd o_cmd
);
    import hrsh_pkg::*;

    t_state r_state, n_state;
    logic [PIECE_W-1:0] r_piece, n_piece;
    logic [ROUND_W-1:0] r_round, n_round;
    logic [STAGE_W-1:0] r_stage, n_stage;
    logic last_piece;

    assign last_piece = ({{(USED_W-PIECE_W){1'b0}}, r_piece} + USED_W'(1)) == i_sts.used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_piece <= '0;
            r_round <= '0;
            r_stage <= '0;
        end else begin
            r_state <= n_state;
            r_piece <= n_piece;
            r_round <= n_round;
            r_stage <= n_stage;
        end
    end

    always_comb begin
        n_state = r_state;
        n_piece = r_piece;
        n_round = r_round;
        n_stage = r_stage;
        unique case (r_state)
            ST_IDLE: begin
                if (i_sts.start) begin
                    n_state = ST_LOAD;
                    n_piece = '0;
                end
            end
            ST_LOAD: begin
                n_state = ST_FLIP;
                n_round = '0;
            end
            ST_FLIP: begin
                n_state = ST_STAGE;
                n_stage = '0;
            end
            ST_STAGE: begin
                if (r_stage == STAGE_W'(STAGES - 1)) begin
                    if (r_round == ROUND_W'(ROUNDS - 1)) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_round = r_round + ROUND_W'(1);
                        n_state = ST_FLIP;
                    end
                end else begin
                    n_stage = r_stage + STAGE_W'(1);
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    if (last_piece) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_piece = r_piece + PIECE_W'(1);
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.stage    = r_stage;
        o_cmd.round    = r_round;
        o_cmd.piece    = r_piece;
        o_cmd.busy     = (r_state != ST_IDLE);
        o_cmd.load     = (r_state == ST_LOAD);
        o_cmd.flip     = (r_state == ST_FLIP);
        o_cmd.stage_en = (r_state == ST_STAGE);
        o_cmd.emit     = (r_state == ST_EMIT) && i_sts.out_free;
    end

endmodule

// File: rtl/hrsh_dp.sv
module hrsh_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hrsh_pkg::t_cmd                  i_cmd,
    output hrsh_pkg::t_sts                  o_sts,
    input  logic                            i_cfg_we,
    input  logic [hrsh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hrsh_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_xfer,
    input  logic                            i_action,
    input  logic [1:0]                      i_flip_round,
    input  logic [1:0]                      i_flip_piece,
    input  logic [63:0]                     i_flip_word,
    input  logic signed [15:0]              i_sample,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [63:0]                     o_hash_word,
    output logic [1:0]                      o_piece_index,
    output logic                            o_last_word
);
    import hrsh_pkg::*;

    logic [LEN_W-1:0] r_vlen;
    logic [HC_W-1:0]  r_hc;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic signed [SAMPLE_W-1:0] r_cap [PIECE_SIZE];
    logic [WORD_W-1:0] r_mask [MASK_N];
    logic signed [ACC_W-1:0] r_row [PIECE_SIZE];
    logic signed [ACC_W-1:0] n_row [PIECE_SIZE];
    logic r_out_valid;
    logic [WORD_W-1:0] r_out_word, n_out_word;
    logic [PIECE_W-1:0] r_out_piece;
    logic r_out_last;

    logic [LEN_W-1:0] len, pos;
    logic [HC_W-1:0]  hc;
    logic [HC_W:0]    hc_round;
    logic [USED_W-1:0] used;
    logic complete;
    logic [MASK_AW-1:0] mask_addr;
    logic [WORD_W-1:0] mask;
    logic out_free;

    // clamp the configuration to the legal ranges
    always_comb begin
        if (r_vlen == '0)                   len = LEN_W'(1);
        else if (r_vlen > LEN_W'(PIECE_SIZE)) len = LEN_W'(PIECE_SIZE);
        else                                len = r_vlen;
        if (r_hc == '0)                   hc = HC_W'(1);
        else if (r_hc > HC_W'(HC_MAX))    hc = HC_W'(HC_MAX);
        else                              hc = r_hc;
        hc_round = {1'b0, hc} + (HC_W+1)'(PIECE_SIZE - 1);
        used     = USED_W'(hc_round / PIECE_SIZE);
        pos      = (r_cnt < len) ? r_cnt : len - LEN_W'(1);
        complete = (pos + LEN_W'(1)) >= len;
    end

    assign mask_addr = MASK_AW'(i_cmd.round * PIECES + i_cmd.piece);
    assign mask      = r_mask[mask_addr];
    assign out_free  = !r_out_valid || !i_stall;

    assign o_sts.start    = i_in_xfer && (i_action == ACT_SAMPLE) && complete;
    assign o_sts.out_free = out_free;
    assign o_sts.used     = used;

    always_comb begin
        n_cnt = r_cnt;
        if (i_in_xfer && i_action == ACT_SAMPLE) begin
            n_cnt = complete ? '0 : pos + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen      <= LEN_W'(64);
            r_hc        <= HC_W'(64);
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < PIECE_SIZE; j++) r_cap[j] <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_VECTOR_LENGTH) r_vlen <= i_cfg_data[LEN_W-1:0];
            if (i_cfg_we && i_cfg_index == REG_HASH_COUNT)    r_hc   <= i_cfg_data[HC_W-1:0];
            r_cnt <= n_cnt;
            if (i_in_xfer && i_action == ACT_SAMPLE) r_cap[pos[CNT_W-1:0]] <= i_sample;
            if (i_cmd.emit)      r_out_valid <= 1'b1;
            else if (!i_stall)   r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_xfer && i_action == ACT_LOAD_MASK &&
            int'(i_flip_round) < ROUNDS && int'(i_flip_piece) < PIECES) begin
            r_mask[MASK_AW'(i_flip_round * PIECES + i_flip_piece)] <= i_flip_word;
        end
    end

    // one command per cycle on the whole piece row
    always_comb begin
        int p;
        for (int j = 0; j < PIECE_SIZE; j++) begin
            n_row[j] = r_row[j];
            p = j ^ (1 << i_cmd.stage);
            if (i_cmd.load) begin
                n_row[j] = (LEN_W'(j) < len) ? ACC_W'(r_cap[j]) : '0;
            end else if (i_cmd.flip) begin
                if (j < WORD_W && mask[j]) n_row[j] = -r_row[j];
            end else if (i_cmd.stage_en) begin
                if (((j >> i_cmd.stage) & 1) == 0) begin
                    if (p < PIECE_SIZE) n_row[j] = r_row[j] + r_row[p[CNT_W-1:0]];
                end else begin
                    n_row[j] = r_row[p[CNT_W-1:0]] - r_row[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < PIECE_SIZE; j++) r_row[j] <= n_row[j];
    end

    always_comb begin
        n_out_word = '0;
        for (int j = 0; j < PIECE_SIZE && j < WORD_W; j++) begin
            n_out_word[j] = ((PIECE_SIZE * int'(i_cmd.piece) + j) < int'(hc)) &&
                            (r_row[j] > 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_word  <= n_out_word;
            r_out_piece <= i_cmd.piece;
            r_out_last  <= ({{(USED_W-PIECE_W){1'b0}}, i_cmd.piece} + USED_W'(1)) == used;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hash_word   = r_out_word;
    assign o_piece_index = r_out_piece;
    assign o_last_word   = r_out_last;

endmodule

// File: rtl/hadamard_rotation_sign_hash_unit.sv
// sign-bit hash of a sample vector by three rounds, each a random sign flip
// and a 64-point walsh-hadamard transform, per piece
//
// input channel (i_valid / o_stall): each transfer is a mask load (action 0,
// one 64-bit flip word per round and piece) or one vector sample (action 1).
// samples stream in order; the sample that completes vector_length starts
// the hash. mask loads and samples are accepted only while the block is idle.
// output channel (o_valid / i_stall): one hash word per used piece, in piece
// order, last_word set on the final one.
// sequence: per piece a load step, then per round a flip step and 6
// butterfly stage steps on the full 64-lane row register, then an emit
// step that waits for a free output register; o_stall is high throughout,
// for up to four pieces. the butterfly row is the bottleneck.
// a stalled receiver holds the output register and the block waits before
// emitting the next word. reset clears the sample count, the captured vector
// and output valid and sets vector_length and hash_count to 64; flip masks
// must be loaded before use. the user must write config (i_cfg_we /
// i_cfg_index / i_cfg_data) only while idle; the block does not enforce it.
module hadamard_rotation_sign_hash_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hrsh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hrsh_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_action,
    input  logic [1:0]                      i_flip_round,
    input  logic [1:0]                      i_flip_piece,
    input  logic [63:0]                     i_flip_word,
    input  logic signed [15:0]              i_sample,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [63:0]                     o_hash_word,
    output logic [1:0]                      o_piece_index,
    output logic                            o_last_word
);
    import hrsh_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_xfer;

    assign o_stall = cmd.busy;
    assign in_xfer = i_valid && !cmd.busy;

    hrsh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    hrsh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_xfer     (in_xfer),
        .i_action      (i_action),
        .i_flip_round  (i_flip_round),
        .i_flip_piece  (i_flip_piece),
        .i_flip_word   (i_flip_word),
        .i_sample      (i_sample),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_hash_word   (o_hash_word),
        .o_piece_index (o_piece_index),
        .o_last_word   (o_last_word)
    );

endmodule

// File: rtl/hrsh_checker.sv
module hrsh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_hash_word,
    input logic        o_last_word
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hash_word))
        else $error("stalled output word changed");

    // while a non-final word waits the block is still working on the vector
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_word |-> o_stall)
        else $error("input open before the vector finished");

    // after a non-final word transfers, another word is out or still in work
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_word |=> o_stall || o_valid)
        else $error("block went idle after a non-final word");

endmodule

bind hadamard_rotation_sign_hash_unit hrsh_checker u_hrsh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_hash_word (o_hash_word),
    .o_last_word (o_last_word)
);

// File: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrsh_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int IDLE_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 250;

    typedef struct {
        logic [WORD_W-1:0]  word;
        logic [PIECE_W-1:0] piece;
        logic               last;
    } t_hash_word;

    class hash_scoreboard;
        logic [WORD_W-1:0]   masks [MASK_N];
        logic signed [15:0]  vec [PIECE_SIZE];
        int                  count;
        logic [LEN_W-1:0]    vlen;
        logic [HC_W-1:0]     hcnt;
        t_hash_word          pending_words [$];
        int                  errors;
        int                  words_seen;
        int                  vectors_done;

        function void reset_state();
            count = 0;
            vlen = 64;
            hcnt = 64;
            errors = 0;
            words_seen = 0;
            vectors_done = 0;
            foreach (masks[k]) masks[k] = '0;
            foreach (vec[k]) vec[k] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_VECTOR_LENGTH) vlen = data[LEN_W-1:0];
            else if (idx == REG_HASH_COUNT) hcnt = data[HC_W-1:0];
        endfunction

        // predict the hash words caused by one accepted input transfer
        function void note_input(logic act, logic [1:0] rd, logic [1:0] pc,
                                 logic [63:0] w, logic signed [15:0] s);
            int len, hc, used, pos, step;
            longint v [PIECE_SIZE];
            longint a, b;
            t_hash_word hw;
            if (act == ACT_LOAD_MASK) begin
                if (rd < ROUNDS && pc < PIECES) masks[rd*PIECES+pc] = w;
                return;
            end
            len = vlen;
            if (len < 1) len = 1;
            if (len > PIECE_SIZE) len = PIECE_SIZE;
            pos = (count < len) ? count : len - 1;
            vec[pos] = s;
            if (pos + 1 < len) begin
                count = pos + 1;
                return;
            end
            count = 0;
            vectors_done++;
            hc = hcnt;
            if (hc < 1) hc = 1;
            if (hc > HC_MAX) hc = HC_MAX;
            used = (hc + PIECE_SIZE - 1) / PIECE_SIZE;
            for (int p = 0; p < used; p++) begin
                for (int j = 0; j < PIECE_SIZE; j++) v[j] = (j < len) ? longint'(vec[j]) : 0;
                for (int r = 0; r < ROUNDS; r++) begin
                    for (int j = 0; j < PIECE_SIZE; j++)
                        if (masks[r*PIECES+p][j]) v[j] = -v[j];
                    for (step = 1; step < PIECE_SIZE; step = step << 1)
                        for (int i = 0; i < PIECE_SIZE; i += 2*step)
                            for (int j = i; j < i + step && j + step < PIECE_SIZE; j++) begin
                                a = v[j];
                                b = v[j+step];
                                v[j] = a + b;
                                v[j+step] = a - b;
                            end
                end
                hw.word = '0;
                for (int j = 0; j < PIECE_SIZE; j++)
                    if (p*PIECE_SIZE + j < hc && v[j] > 0) hw.word[j] = 1'b1;
                hw.piece = p[PIECE_W-1:0];
                hw.last = (p + 1 == used);
                pending_words.push_back(hw);
            end
        endfunction

        function void check_word(logic [63:0] word, logic [1:0] piece, logic last);
            t_hash_word hw;
            words_seen++;
            if (pending_words.size() == 0) begin
                $error("unexpected hash word %h piece %0d", word, piece);
                errors++;
                return;
            end
            hw = pending_words.pop_front();
            if (word !== hw.word) begin
                $error("hash_word expected %h actual %h", hw.word, word);
                errors++;
            end
            if (piece !== hw.piece) begin
                $error("piece_index expected %0d actual %0d", hw.piece, piece);
                errors++;
            end
            if (last !== hw.last) begin
                $error("last_word expected %0d actual %0d", hw.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_action = 1'b0;
    logic [1:0]           i_flip_round = '0;
    logic [1:0]           i_flip_piece = '0;
    logic [63:0]          i_flip_word = '0;
    logic signed [15:0]   i_sample = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [63:0]          o_hash_word;
    logic [1:0]           o_piece_index;
    logic                 o_last_word;

    hash_scoreboard sb = new();
    bit quiet;
    bit hold_req;
    int items_sent;
    int idle_count;

    hadamard_rotation_sign_hash_unit dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        if (quiet) return 0;
        return $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : $urandom_range(0, 2);
    endfunction

    task automatic send(logic act, logic [1:0] rd, logic [1:0] pc,
                        logic [63:0] w, logic signed [15:0] s);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_flip_round <= rd;
        i_flip_piece <= pc;
        i_flip_word <= w;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(act, rd, pc, w, s);
        items_sent++;
    endtask

    task automatic send_sample(logic signed [15:0] s);
        send(ACT_SAMPLE, 2'($urandom), 2'($urandom), {$urandom, $urandom}, s);
    endtask

    task automatic send_mask(logic [1:0] rd, logic [1:0] pc, logic [63:0] w);
        send(ACT_LOAD_MASK, rd, pc, w, 16'($urandom));
    endtask

    // only while the block is idle and every hash word has come back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 3)) - 16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        sb.reset_state();
        forever begin
            int gap;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (!i_stall) sb.check_word(o_hash_word, o_piece_index, o_last_word);
            if (hold_req) begin
                // long receiver hold-off so the block backs up into its input
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else begin
                gap = draw_gap();
                if (gap > 0) begin
                    i_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        int phase;
        int vl, hc;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, 9'd5);
        for (int r = 0; r < ROUNDS; r++)
            for (int p = 0; p < PIECES; p++)
                send_mask(r[1:0], p[1:0], (r == 0 && p == 0) ? '1 :
                          (r == 1 && p == 0) ? '0 : {$urandom, $urandom});
        send_mask(2'd3, 2'd1, '1);
        send_mask(2'd3, 2'd3, {$urandom, $urandom});

        write_reg(REG_VECTOR_LENGTH, 9'd3);
        write_reg(REG_HASH_COUNT, 9'd256);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        // shrink the length under a partly filled vector
        write_reg(REG_VECTOR_LENGTH, 9'd1);
        send_sample(16'sd5);
        write_reg(REG_VECTOR_LENGTH, 9'd0);
        write_reg(REG_HASH_COUNT, 9'd0);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        write_reg(REG_VECTOR_LENGTH, 9'd127);
        write_reg(REG_HASH_COUNT, 9'd511);
        for (int k = 0; k < 64; k++) send_sample(rand_sample());

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0: vl = 64;
                1: vl = $urandom_range(0, 1) ? 0 : 127;
                default: vl = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 5))
                0: hc = 0;
                1: hc = 511;
                2: hc = 256;
                default: hc = $urandom_range(1, 256);
            endcase
            if (phase == 2) vl = 2;
            write_reg(REG_VECTOR_LENGTH, vl[CFG_W-1:0]);
            write_reg(REG_HASH_COUNT, hc[CFG_W-1:0]);
            quiet = (phase % 4 == 1);
            if (phase == 2) hold_req = 1'b1;
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_mask(2'($urandom), 2'($urandom), {$urandom, $urandom});
                else
                    send_sample(rand_sample());
            end
            phase++;
        end
        quiet = 1'b0;
        i_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
        $display("tb: %0d hash vectors, %0d words checked over %0d random phases",
                 sb.vectors_done, sb.words_seen, phase);
        $display("tb: lengths and hash counts swept incl. clamped extremes and a long hold-off");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
